@@ design/nsst_pkg.sv @@
// Package for the nested scope symbol table: sizes, codes, transaction types
// and the name cleanup function. Depends on nothing; the top module imports it.
package nsst_pkg;

   // Table sizes.
   localparam int MAX_SCOPES = 16;
   localparam int ENTRIES    = 256;
   localparam int NAME_CHARS = 3;

   // Derived widths.
   localparam int NAME_W   = NAME_CHARS * 8;
   localparam int VALUE_W  = 32;
   localparam int CNT_W    = $clog2(ENTRIES + 1);
   localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int DEPTH_W  = $clog2(MAX_SCOPES + 1);
   localparam int SIDX_W   = (MAX_SCOPES > 1) ? $clog2(MAX_SCOPES) : 1;

   // Operation codes.
   typedef enum logic [1:0] {
      FUNC_OPEN   = 2'd0,
      FUNC_CLOSE  = 2'd1,
      FUNC_ASSIGN = 2'd2,
      FUNC_LOOKUP = 2'd3
   } func_type;

   // Result status codes.
   typedef enum logic [2:0] {
      STATUS_OK         = 3'd0,
      STATUS_NO_SCOPE   = 3'd1,
      STATUS_TABLE_FULL = 3'd2,
      STATUS_STACK_FULL = 3'd3,
      STATUS_NOT_FOUND  = 3'd4
   } status_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CLOSE_WAIT,
      ST_ASSIGN_BASE,
      ST_SCAN
   } state_type;

   // Request transaction.
   typedef struct packed {
      func_type                   func;
      logic [NAME_W-1:0]          name;
      logic signed [VALUE_W-1:0]  value;
   } req_type;

   // Response transaction.
   typedef struct packed {
      status_type                 status;
      logic signed [VALUE_W-1:0]  read_value;
   } rsp_type;

   // One stored symbol.
   typedef struct packed {
      logic [NAME_W-1:0]          name;
      logic [VALUE_W-1:0]         value;
   } entry_type;

   // Keep the characters up to the first zero byte; later ones read as zero.
   function automatic logic [NAME_W-1:0] clean_name(input logic [NAME_W-1:0] raw);
      logic [NAME_W-1:0] res;
      logic              stop;
      res  = '0;
      stop = 1'b0;
      for (int k = NAME_CHARS - 1; k >= 0; k--) begin
         if (raw[8*k +: 8] == 8'h00) begin
            stop = 1'b1;
         end
         if (!stop) begin
            res[8*k +: 8] = raw[8*k +: 8];
         end
      end
      return res;
   endfunction

endpackage

@@ design/nsst_ram.sv @@
// Generic single-port-write, single-port-read synchronous RAM with a
// registered read port. Depends on nothing.
module nsst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/nested_scope_symbol_table_top.sv @@
// Nested scope symbol table. Open answers straight from idle; close first reads the
// popped scope base; assign reads the innermost scope base, then scans its entries;
// lookup scans the live entries; close or assign with no open scope answers from idle.
// One transaction at a time; the next one is accepted at the edge that ends the
// response strobe. The response strobe lasts one cycle; the receiver cannot stall it.
// Synchronous reset clears scope depth, entry count and default value; no clearing pass.
module nested_scope_symbol_table_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  nsst_pkg::req_type req_data,
   output logic              rsp_valid,
   output nsst_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [31:0]       csr_data
);

   import nsst_pkg::*;

   // Control registers.
   state_type                state_ff, state_in;
   logic [DEPTH_W-1:0]       depth_ff, depth_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         scan_addr_ff, scan_addr_in;
   logic                     pend_ff, pend_in;
   logic [IDX_W-1:0]         pend_addr_ff, pend_addr_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]       default_ff, default_in;

   // Latched request and response payload.
   req_type                  req_ff, req_in;
   rsp_type                  rsp_ff, rsp_in;

   // Memory interfaces.
   logic                     sc_wr_en, sc_rd_en;
   logic [SIDX_W-1:0]        sc_wr_addr, sc_rd_addr;
   logic [CNT_W-1:0]         sc_wr_data, sc_rd_data;
   logic                     en_wr_en, en_rd_en;
   logic [IDX_W-1:0]         en_wr_addr, en_rd_addr;
   entry_type                en_wr_data, en_rd_data;

   logic                     accept;
   logic [DEPTH_W-1:0]       depth_m1;
   logic                     hit;
   logic                     more;
   logic                     is_assign;

   // Scope base stack.
   nsst_ram #(.WIDTH(CNT_W), .DEPTH(MAX_SCOPES)) u_scope_ram (
      .clock   (clock),
      .wr_en   (sc_wr_en),
      .wr_addr (sc_wr_addr),
      .wr_data (sc_wr_data),
      .rd_en   (sc_rd_en),
      .rd_addr (sc_rd_addr),
      .rd_data (sc_rd_data)
   );

   // Entry stack, name and value side by side.
   nsst_ram #(.WIDTH($bits(entry_type)), .DEPTH(ENTRIES)) u_entry_ram (
      .clock   (clock),
      .wr_en   (en_wr_en),
      .wr_addr (en_wr_addr),
      .wr_data (en_wr_data),
      .rd_en   (en_rd_en),
      .rd_addr (en_rd_addr),
      .rd_data (en_rd_data)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = !busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign depth_m1  = depth_ff - 1'b1;
   assign is_assign = (req_ff.func == FUNC_ASSIGN);
   // The entry returned this cycle matches the requested name.
   assign hit       = pend_ff && (en_rd_data.name == req_ff.name);
   // Assign scans upward to the top of the stack, lookup downward to the bottom.
   assign more      = is_assign ? (scan_addr_ff < count_ff) : (scan_addr_ff != '0);

   // State register and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         depth_ff     <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         default_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         default_ff   <= default_in;
      end
   end

   // Payload and scan pointers need no reset.
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      rsp_ff       <= rsp_in;
      scan_addr_ff <= scan_addr_in;
      pend_addr_ff <= pend_addr_in;
   end

   // Next state, memory accesses and response.
   always_comb begin
      state_in     = state_ff;
      depth_in     = depth_ff;
      count_in     = count_ff;
      scan_addr_in = scan_addr_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      rsp_valid_in = 1'b0;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      default_in   = default_ff;

      sc_wr_en     = 1'b0;
      sc_wr_addr   = depth_ff[SIDX_W-1:0];
      sc_wr_data   = count_ff;
      sc_rd_en     = 1'b0;
      sc_rd_addr   = depth_m1[SIDX_W-1:0];
      en_wr_en     = 1'b0;
      en_wr_addr   = count_ff[IDX_W-1:0];
      en_wr_data   = '{name: req_ff.name, value: req_ff.value};
      en_rd_en     = 1'b0;
      en_rd_addr   = scan_addr_ff[IDX_W-1:0];

      // Configuration write.
      if (csr_valid && csr_ready) begin
         default_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in      = req_data;
               req_in.name = clean_name(req_data.name);
               rsp_in      = '{status: STATUS_OK, read_value: '0};
               case (req_data.func)
                  FUNC_OPEN: begin
                     // Push the current entry count as the new scope base.
                     rsp_valid_in = 1'b1;
                     if (depth_ff == DEPTH_W'(MAX_SCOPES)) begin
                        rsp_in.status = STATUS_STACK_FULL;
                     end else begin
                        sc_wr_en = 1'b1;
                        depth_in = depth_ff + 1'b1;
                     end
                  end
                  FUNC_CLOSE: begin
                     // Pop the scope and fetch its base to truncate the entries.
                     if (depth_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = STATUS_NO_SCOPE;
                     end else begin
                        sc_rd_en = 1'b1;
                        depth_in = depth_m1;
                        state_in = ST_CLOSE_WAIT;
                     end
                  end
                  FUNC_ASSIGN: begin
                     // Fetch the innermost scope base, the start of the scan.
                     if (depth_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = STATUS_NO_SCOPE;
                     end else begin
                        sc_rd_en = 1'b1;
                        state_in = ST_ASSIGN_BASE;
                     end
                  end
                  default: begin
                     // Lookup scans from the newest entry down.
                     scan_addr_in = count_ff;
                     state_in     = ST_SCAN;
                  end
               endcase
            end
         end
         ST_CLOSE_WAIT: begin
            count_in     = sc_rd_data;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_ASSIGN_BASE: begin
            scan_addr_in = sc_rd_data;
            state_in     = ST_SCAN;
         end
         ST_SCAN: begin
            if (hit) begin
               // Found: overwrite on assign, return the value on lookup.
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (is_assign) begin
                  en_wr_en   = 1'b1;
                  en_wr_addr = pend_addr_ff;
               end else begin
                  rsp_in.read_value = en_rd_data.value;
               end
            end else if (more) begin
               // Issue the next read; its data is checked next cycle.
               en_rd_en = 1'b1;
               pend_in  = 1'b1;
               if (is_assign) begin
                  en_rd_addr   = scan_addr_ff[IDX_W-1:0];
                  scan_addr_in = scan_addr_ff + 1'b1;
               end else begin
                  en_rd_addr   = IDX_W'(scan_addr_ff - 1'b1);
                  scan_addr_in = scan_addr_ff - 1'b1;
               end
               pend_addr_in = en_rd_addr;
            end else begin
               // Not found: append on assign, default on lookup.
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (is_assign) begin
                  if (count_ff == CNT_W'(ENTRIES)) begin
                     rsp_in.status = STATUS_TABLE_FULL;
                  end else begin
                     en_wr_en = 1'b1;
                     count_in = count_ff + 1'b1;
                  end
               end else begin
                  rsp_in.status     = STATUS_NOT_FOUND;
                  rsp_in.read_value = default_ff;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef NO_ASSERTIONS
   // Counts never pass their table sizes.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(ENTRIES))
      else $error("entry count beyond table size");

   a_depth_range: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEPTH_W'(MAX_SCOPES))
      else $error("scope depth beyond stack size");

   // A pending scan read always points at a live entry.
   a_pend_live: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (CNT_W'(pend_addr_ff) < count_ff))
      else $error("scan read outside live entries");

   // The response strobe never overlaps a running transaction.
   a_rsp_not_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !rsp_valid_ff)
      else $error("response while busy");

   // A response follows either an accept or the last busy cycle.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(start && !busy) || $past(busy)))
      else $error("response without a transaction");
`endif

endmodule
